/* design/brf_pkg.sv */
// Shared definitions for the circular byte FIFO: field widths, operation
// codes and the control struct between the pointer unit and the top level.
// No dependencies.
`default_nettype none

package brf_pkg;

    localparam int MODE_W       = 3;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 11;
    localparam int CAPACITY_DEF = 1024;

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    typedef struct packed {
        logic ok;
        logic rd;
        logic wr;
    } brf_op_t;

endpackage

`default_nettype wire

/* design/brf_ptr.sv */
// Head, tail and fill level of the circular byte FIFO; decodes one item into
// memory read/write commands and the next fill level.
// Depends on brf_pkg.
`default_nettype none

module brf_ptr #(
    parameter int CAPACITY = brf_pkg::CAPACITY_DEF,
    localparam int AW = $clog2(CAPACITY),
    localparam int FW = $clog2(CAPACITY + 1)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         accept_i,
    input  wire logic [brf_pkg::MODE_W-1:0]   mode_i,
    input  wire logic [brf_pkg::CNT_W-1:0]    count_i,
    output brf_pkg::brf_op_t                  op_o,
    output logic [AW-1:0]                     rd_addr_o,
    output logic [AW-1:0]                     wr_addr_o,
    output logic [FW-1:0]                     fill_next_o
);

    localparam int CW = (FW > brf_pkg::CNT_W) ? FW : brf_pkg::CNT_W;
    localparam int SW = FW + 1;
    localparam logic [FW-1:0] CAP_F  = FW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
    localparam logic [AW-1:0] LAST_A = AW'(CAPACITY - 1);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next;

    logic [CW-1:0] cnt_ext;
    logic [CW-1:0] fill_ext;
    logic          cnt_lt;
    logic          cnt_le;
    logic [FW-1:0] cnt_f;
    logic [FW-1:0] off_f;
    logic [SW-1:0] sum_s;
    logic [SW-1:0] sum_wrap;
    logic [AW-1:0] head_adv;
    logic [AW-1:0] tail_adv;

    assign cnt_ext  = CW'(count_i);
    assign fill_ext = CW'(fill_reg);
    assign cnt_lt   = cnt_ext < fill_ext;
    assign cnt_le   = cnt_ext <= fill_ext;
    assign cnt_f    = cnt_lt ? cnt_ext[FW-1:0] : fill_reg;
    assign off_f    = (mode_i == brf_pkg::MODE_POP) ? FW'(1) : cnt_f;
    assign sum_s    = SW'(head_reg) + SW'(off_f);
    assign sum_wrap = (sum_s >= CAP_S) ? (sum_s - CAP_S) : sum_s;
    assign head_adv = sum_wrap[AW-1:0];
    assign tail_adv = (tail_reg == LAST_A) ? '0 : (tail_reg + AW'(1));

    assign rd_addr_o   = (mode_i == brf_pkg::MODE_PEEK) ? head_adv : head_reg;
    assign wr_addr_o   = tail_reg;
    assign fill_next_o = fill_next;

    always_comb begin
        op_o      = '0;
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        unique case (mode_i)
            brf_pkg::MODE_PUSH: begin
                if (fill_reg != CAP_F) begin
                    op_o.ok   = 1'b1;
                    op_o.wr   = 1'b1;
                    tail_next = tail_adv;
                    fill_next = fill_reg + FW'(1);
                end
            end
            brf_pkg::MODE_POP: begin
                if (fill_reg != '0) begin
                    op_o.ok   = 1'b1;
                    op_o.rd   = 1'b1;
                    head_next = head_adv;
                    fill_next = fill_reg - FW'(1);
                end
            end
            brf_pkg::MODE_PEEK: begin
                op_o.ok = cnt_lt;
                op_o.rd = cnt_lt;
            end
            brf_pkg::MODE_DISCARD: begin
                op_o.ok   = cnt_le;
                head_next = head_adv;
                fill_next = fill_reg - cnt_f;
            end
            brf_pkg::MODE_CLEAR: begin
                op_o.ok   = 1'b1;
                head_next = '0;
                tail_next = '0;
                fill_next = '0;
            end
            default: begin
                op_o = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else if (accept_i) begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CAP_F)
        else $error("fill level above capacity");

    a_ptr_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        (((SW'(head_reg) + SW'(fill_reg)) >= CAP_S)
            ? (SW'(head_reg) + SW'(fill_reg) - CAP_S)
            : (SW'(head_reg) + SW'(fill_reg))) == SW'(tail_reg))
        else $error("tail does not match head plus fill");

    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept_i && (mode_i == brf_pkg::MODE_PUSH) && (fill_reg == CAP_F))
            |=> $stable(fill_reg) && $stable(tail_reg))
        else $error("push on full queue changed state");
`endif

endmodule

`default_nettype wire

/* design/byte_ring_fifo_core.sv */
// Top level of the circular byte FIFO: stream ports, byte memory and result
// register stages.
// Depends on brf_pkg and brf_ptr.
`default_nettype none

// Circular byte queue of CAPACITY bytes. Each input item carries one
// operation (push, pop, peek at offset, discard count, clear) and yields
// exactly one result item with the byte read, a success flag and the used
// and free counts after the operation. Items are accepted every cycle while
// the result side keeps up; the byte memory is read into a register on
// acceptance and the output register loads from that read stage once the
// output side can take the result. Pointers and fill level update on
// acceptance, so a pop or peek directly after a push sees the pushed byte.
// Used and free counts are reported modulo 2048.
module byte_ring_fifo_core #(
    parameter int CAPACITY = brf_pkg::CAPACITY_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // mode[2:0], byte_in[10:3], count[21:11]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // data_out[7:0], ok[8], used_count[19:9],
                                        // free_count[30:20]
);

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);
    localparam logic [FW-1:0] CAP_F = FW'(CAPACITY);

    logic [brf_pkg::MODE_W-1:0] s_mode;
    logic [brf_pkg::BYTE_W-1:0] s_byte;
    logic [brf_pkg::CNT_W-1:0]  s_count;

    logic                       accept;
    logic                       p1_adv;
    brf_pkg::brf_op_t           op;
    logic [AW-1:0]              rd_addr;
    logic [AW-1:0]              wr_addr;
    logic [FW-1:0]              fill_next;
    logic [FW-1:0]              free_next;

    logic [brf_pkg::BYTE_W-1:0] mem [CAPACITY];
    logic [brf_pkg::BYTE_W-1:0] rdata_reg;

    logic                       p1_valid_reg, p1_valid_next;
    logic                       p1_ok_reg;
    logic                       p1_rd_reg;
    logic [brf_pkg::CNT_W-1:0]  p1_used_reg;
    logic [brf_pkg::CNT_W-1:0]  p1_free_reg;

    logic                       m_valid_reg, m_valid_next;
    logic [brf_pkg::BYTE_W-1:0] m_data_reg;
    logic                       m_ok_reg;
    logic [brf_pkg::CNT_W-1:0]  m_used_reg;
    logic [brf_pkg::CNT_W-1:0]  m_free_reg;

    assign s_mode  = s_tdata[2:0];
    assign s_byte  = s_tdata[10:3];
    assign s_count = s_tdata[21:11];

    assign p1_adv   = p1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_adv;
    assign accept   = s_tvalid && s_tready;

    brf_ptr #(
        .CAPACITY (CAPACITY)
    ) u_ptr (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept_i    (accept),
        .mode_i      (s_mode),
        .count_i     (s_count),
        .op_o        (op),
        .rd_addr_o   (rd_addr),
        .wr_addr_o   (wr_addr),
        .fill_next_o (fill_next)
    );

    assign free_next = CAP_F - fill_next;

    always_ff @(posedge aclk) begin
        if (accept && op.wr) begin
            mem[wr_addr] <= s_byte;
        end
        if (accept && op.rd) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign p1_valid_next = accept || (p1_valid_reg && !p1_adv);
    assign m_valid_next  = p1_adv || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_ok_reg   <= op.ok;
            p1_rd_reg   <= op.rd;
            p1_used_reg <= brf_pkg::CNT_W'(fill_next);
            p1_free_reg <= brf_pkg::CNT_W'(free_next);
        end
        if (p1_adv) begin
            m_data_reg <= p1_rd_reg ? rdata_reg : '0;
            m_ok_reg   <= p1_ok_reg;
            m_used_reg <= p1_used_reg;
            m_free_reg <= p1_free_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_free_reg, m_used_reg, m_ok_reg, m_data_reg};

`ifndef SYNTH
    a_accept_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> p1_valid_reg)
        else $error("accepted item lost before read stage");

    a_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ok_reg) |-> (m_data_reg == '0))
        else $error("failed operation returned nonzero data");

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (brf_pkg::CNT_W'(m_used_reg + m_free_reg)
            == brf_pkg::CNT_W'(CAPACITY)))
        else $error("used and free counts do not add up to capacity");
`endif

endmodule

`default_nettype wire
